// File: src/mbpt_pkg.sv
package mbpt_pkg;

    localparam int CANVAS_BYTES = 1024;
    localparam int ADDR_W       = 10;
    localparam int BYTE_W       = 8;
    localparam int BIT_IDX_W    = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_FLUSH
    } t_state;

    // Canvas byte feeding bit k of panel byte o:
    // {o[9:7], k, o[6:4], o[3]}
    function automatic logic [ADDR_W-1:0] source_addr(
        input logic [ADDR_W-1:0]    o,
        input logic [BIT_IDX_W-1:0] k
    );
        source_addr = {o[9:7], k, o[6:4], o[3]};
    endfunction

endpackage

// File: src/mbpt_ram.sv
module mbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/mono_bitmap_page_transposer.sv
// mono_bitmap_page_transposer
//
// Holds a 128x64 one-bit canvas (1024 bytes) and returns it in panel byte
// order, each panel byte being one bit column gathered from eight canvas
// bytes.
//
// Input channel (i_in_valid / o_in_ready): i_op selects a write (store
// i_write_byte at canvas i_address) or a read (return panel byte
// i_address). Output channel (o_out_valid / i_out_ready): one o_read_byte
// per read, none per write.
//
// Input acceptance: a write is taken in idle and the block stays idle, so
// writes may follow back to back. A read holds off the input from its
// transfer until the next input is taken: the transfer, eight memory reads,
// one per source byte, then the read latency and the output load, which
// waits for a free output register. The single RAM read port sets this.
//
// Reset clears control state only; canvas contents are undefined until
// written. If the receiver stalls, the finished byte waits in the output
// register; a following write is still taken, a following read runs and
// then holds in its flush step until the output register drains.
module mono_bitmap_page_transposer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [mbpt_pkg::ADDR_W-1:0]    i_address,
    input  logic [mbpt_pkg::BYTE_W-1:0]    i_write_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mbpt_pkg::BYTE_W-1:0]    o_read_byte
);

    import mbpt_pkg::*;

    t_state                r_state, n_state;
    logic [BIT_IDX_W-1:0]  r_k, n_k;          // next source byte to fetch
    logic [ADDR_W-1:0]     r_addr, n_addr;    // panel byte being built
    logic [BYTE_W-1:0]     r_acc, n_acc;      // gathered bits
    logic                  r_dv, n_dv;        // RAM data valid this cycle
    logic [BIT_IDX_W-1:0]  r_dk, n_dk;        // which bit that data feeds
    logic                  r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]     r_out_byte, n_out_byte;

    logic                  w_accept;
    logic                  w_we;
    logic                  w_re;
    logic [ADDR_W-1:0]     w_raddr;
    logic [BYTE_W-1:0]     w_rdata;
    logic                  w_bit;
    logic                  w_out_free;

    mbpt_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CANVAS_BYTES)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_address),
        .i_wdata (i_write_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_we       = w_accept && (i_op == OP_WRITE);
    assign w_re       = (r_state == ST_READ);
    assign w_raddr    = source_addr(r_addr, r_k);
    // bit (7-j) of the returned byte, j = low three address bits
    assign w_bit      = w_rdata[~r_addr[BIT_IDX_W-1:0]];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_addr      = r_addr;
        n_acc       = r_acc;
        n_dv        = 1'b0;
        n_dk        = r_k;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte  = r_out_byte;

        if (r_dv) begin
            n_acc[r_dk] = w_bit;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_op == OP_READ)) begin
                    n_state = ST_READ;
                    n_addr  = i_address;
                    n_k     = '0;
                end
            end
            ST_READ: begin
                n_dv = 1'b1;
                n_k  = r_k + 1'b1;
                if (r_k == '1) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_acc      <= n_acc;
        r_dk       <= n_dk;
        r_out_byte <= n_out_byte;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_byte = r_out_byte;

    // The last gathered bit must land exactly in the step before flush.
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LAST) |-> (r_dv && (r_dk == '1)))
        else $error("last source byte not returning in final gather step");

    // No canvas write may overlap an ongoing gather.
    a_no_write_in_gather: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_we)
        else $error("canvas write during gather");

    // A read transfer starts fetching at source byte zero.
    a_read_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_op == OP_READ)) |=> ((r_state == ST_READ) && (r_k == '0)))
        else $error("read did not start at first source byte");

    // Flush with a free output produces a result and frees the input.
    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FLUSH) && w_out_free) |=> (o_out_valid && o_in_ready))
        else $error("flush did not load output register");

endmodule
